// ===== design/rits_pkg.sv =====
`default_nettype none

package rits_pkg;

	// opcodes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// state codes
	localparam logic [2:0] ST_EMPTY       = 3'd0;
	localparam logic [2:0] ST_NOT_TRACKED = 3'd1;
	localparam logic [2:0] ST_PENDING     = 3'd2;

	// incoming request
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] instance_id;
		logic [3:0]  slot_in;
		logic [2:0]  new_state;
	} cmd_t;

	// outgoing result
	typedef struct packed {
		logic [3:0] slot_out;
		logic [2:0] state_found;
		logic       updated;
	} res_t;

	// table port controls from the sequencer
	typedef struct packed {
		logic rd_en;
		logic id_we;
		logic st_we;
		logic clear;
	} tbl_ctl_t;

endpackage

`default_nettype wire

// ===== design/recent_id_state_tracker.sv =====
`default_nettype none
// Channel  Direction  Handshake             Payload
// cmd      in         cmd_valid / cmd_stall  rits_pkg::cmd_t (opcode, id, slot, state)
// res      out        res_valid / res_stall  rits_pkg::res_t (slot, state found, updated)
//
// Start and clear go from EXEC straight to DONE; update passes through UPCHK between.
// A query walks the table backward one slot a cycle through the single
// registered read port.
// One request at a time: cmd_stall is high from accept until its result moves
// into the output register; a stalled result holds there.
// Reset empties the table at once through per-entry valid flops; no sweep.

module recent_id_state_tracker #(
	parameter int ENTRIES  = 16,
	parameter int ID_WIDTH = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cmd_valid,
	output logic            cmd_stall,
	input  rits_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  wire             res_stall,
	output rits_pkg::res_t  res
);
	import rits_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	tbl_ctl_t            ctl;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [ID_WIDTH-1:0] wr_id;
	logic [2:0]          wr_state;
	logic [ID_WIDTH-1:0] rd_id;
	logic [2:0]          rd_state;
	logic                seq_idle;
	logic                seq_done;
	res_t                seq_res;
	logic                out_free;
	logic                res_valid_q;
	res_t                res_q;

	assign cmd_stall = !seq_idle;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	rits_seq #(
		.ENTRIES  (ENTRIES),
		.ID_WIDTH (ID_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_fire (cmd_valid && seq_idle),
		.cmd      (cmd),
		.out_free (out_free),
		.idle     (seq_idle),
		.done     (seq_done),
		.res      (seq_res),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_id    (wr_id),
		.wr_state (wr_state),
		.rd_id    (rd_id),
		.rd_state (rd_state)
	);

	rits_table #(
		.ENTRIES  (ENTRIES),
		.ID_WIDTH (ID_WIDTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_id    (wr_id),
		.wr_state (wr_state),
		.rd_id    (rd_id),
		.rd_state (rd_state)
	);

	// output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_done && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done && out_free) begin
			res_q <= seq_res;
		end
	end

endmodule

`default_nettype wire

// ===== design/rits_table.sv =====
`default_nettype none

module rits_table #(
	parameter int ENTRIES  = 16,
	parameter int ID_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  rits_pkg::tbl_ctl_t          ctl,
	input  wire [$clog2(ENTRIES)-1:0]   rd_addr,
	input  wire [$clog2(ENTRIES)-1:0]   wr_addr,
	input  wire [ID_WIDTH-1:0]          wr_id,
	input  wire [2:0]                   wr_state,
	output logic [ID_WIDTH-1:0]         rd_id,
	output logic [2:0]                  rd_state
);
	import rits_pkg::*;

	logic [ID_WIDTH-1:0] id_mem [ENTRIES];
	logic [2:0]          st_mem [ENTRIES];

	logic [ENTRIES-1:0]  idv_q;
	logic [ENTRIES-1:0]  stv_q;
	logic [ID_WIDTH-1:0] rd_id_q;
	logic [2:0]          rd_st_q;
	logic                idv_rd_q;
	logic                stv_rd_q;

	// write and registered read of the entry memories
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_id_q <= id_mem[rd_addr];
			rd_st_q <= st_mem[rd_addr];
		end
		if (ctl.id_we) begin
			id_mem[wr_addr] <= wr_id;
		end
		if (ctl.st_we) begin
			st_mem[wr_addr] <= wr_state;
		end
	end

	// track written entries; clear empties all states but keeps ids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idv_q    <= '0;
			stv_q    <= '0;
			idv_rd_q <= 1'b0;
			stv_rd_q <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				idv_rd_q <= idv_q[rd_addr];
				stv_rd_q <= stv_q[rd_addr];
			end
			if (ctl.clear) begin
				stv_q <= '0;
			end else if (ctl.st_we) begin
				stv_q[wr_addr] <= 1'b1;
			end
			if (ctl.id_we) begin
				idv_q[wr_addr] <= 1'b1;
			end
		end
	end

	// unwritten entries read as zero id and empty state
	assign rd_id    = idv_rd_q ? rd_id_q : '0;
	assign rd_state = stv_rd_q ? rd_st_q : ST_EMPTY;

endmodule

`default_nettype wire

// ===== design/rits_seq.sv =====
`default_nettype none

module rits_seq #(
	parameter int ENTRIES  = 16,
	parameter int ID_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cmd_fire,
	input  rits_pkg::cmd_t              cmd,
	input  wire                         out_free,
	output logic                        idle,
	output logic                        done,
	output rits_pkg::res_t              res,
	output rits_pkg::tbl_ctl_t          ctl,
	output logic [$clog2(ENTRIES)-1:0]  rd_addr,
	output logic [$clog2(ENTRIES)-1:0]  wr_addr,
	output logic [ID_WIDTH-1:0]         wr_id,
	output logic [2:0]                  wr_state,
	input  wire [ID_WIDTH-1:0]          rd_id,
	input  wire [2:0]                   rd_state
);
	import rits_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_UPCHK = 5'b00100,
		S_WALK  = 5'b01000,
		S_DONE  = 5'b10000
	} seq_state_t;

	seq_state_t          state_q;
	cmd_t                cmd_q;
	res_t                res_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       ptr_q;
	logic [AW-1:0]       cnt_q;
	logic                chk_q;

	logic                id_match;
	logic                slot_ok;
	logic [AW-1:0]       slot_addr;

	// shared id comparator, used by update and by every query step
	assign id_match  = (rd_id == id_q);
	assign slot_ok   = 32'(cmd_q.slot_in) < ENTRIES;
	assign slot_addr = AW'(cmd_q.slot_in);

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign res  = res_q;

	// drive table ports
	always_comb begin
		ctl      = '0;
		rd_addr  = ptr_q;
		wr_addr  = slot_addr;
		wr_id    = id_q;
		wr_state = cmd_q.new_state;
		unique case (state_q)
			S_EXEC: begin
				unique case (cmd_q.opcode)
					OP_START: begin
						ctl.id_we = 1'b1;
						ctl.st_we = 1'b1;
						wr_addr   = wp_q;
						wr_state  = ST_PENDING;
					end
					OP_UPDATE: begin
						ctl.rd_en = slot_ok;
						rd_addr   = slot_addr;
					end
					OP_QUERY: begin
					end
					OP_CLEAR: begin
						ctl.clear = 1'b1;
					end
				endcase
			end
			S_UPCHK: begin
				ctl.st_we = id_match;
			end
			S_WALK: begin
				ctl.rd_en = 1'b1;
			end
			S_IDLE, S_DONE: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			chk_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q.opcode)
						OP_START: begin
							wp_q    <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
							state_q <= S_DONE;
						end
						OP_UPDATE: begin
							state_q <= slot_ok ? S_UPCHK : S_DONE;
						end
						OP_QUERY: begin
							ptr_q   <= (wp_q == '0) ? LAST : wp_q - 1'b1;
							cnt_q   <= '0;
							chk_q   <= 1'b0;
							state_q <= S_WALK;
						end
						OP_CLEAR: begin
							wp_q    <= '0;
							state_q <= S_DONE;
						end
					endcase
				end
				S_UPCHK: begin
					state_q <= S_DONE;
				end
				S_WALK: begin
					// issue the next read each cycle, check the one before
					ptr_q <= (ptr_q == '0) ? LAST : ptr_q - 1'b1;
					chk_q <= 1'b1;
					if (chk_q) begin
						if (rd_state == ST_EMPTY || id_match || cnt_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// capture request and build the result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_fire) begin
			cmd_q <= cmd;
			id_q  <= ID_WIDTH'(cmd.instance_id);
		end
		if (state_q == S_EXEC) begin
			res_q.slot_out    <= (cmd_q.opcode == OP_START) ? 4'(wp_q) : 4'd0;
			res_q.state_found <= (cmd_q.opcode == OP_QUERY) ? ST_NOT_TRACKED : ST_EMPTY;
			res_q.updated     <= 1'b0;
		end
		if (state_q == S_UPCHK && id_match) begin
			res_q.updated <= 1'b1;
		end
		if (state_q == S_WALK && chk_q && rd_state != ST_EMPTY && id_match) begin
			res_q.state_found <= rd_state;
		end
	end

	// checks
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < ENTRIES)
		else $error("write pointer beyond table");

	a_id_write_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.id_we |-> (state_q == S_EXEC && cmd_q.opcode == OP_START))
		else $error("id written outside start");

	a_upd_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res_q.updated) |-> (cmd_q.opcode == OP_UPDATE))
		else $error("updated flag on non-update request");

	a_query_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_q.opcode == OP_QUERY) |-> (res_q.state_found != ST_EMPTY))
		else $error("query answered empty");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_free) |=> (done && $stable(res_q)))
		else $error("result lost while output busy");

endmodule

`default_nettype wire

// ===== test/tb_recent_id_state_tracker.sv =====
`default_nettype none

module tb_recent_id_state_tracker;
	import rits_pkg::*;

	localparam int N_SLOTS = 16;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	recent_id_state_tracker #(
		.ENTRIES (N_SLOTS),
		.ID_WIDTH(16)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// shadow of the tracking table
	logic [15:0] trk_id [N_SLOTS];
	logic [2:0]  trk_state [N_SLOTS];
	int          trk_wp;

	res_t        want_q [$];
	res_t        due;
	int          n_err = 0;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	// long receiver hold-off: main bumps hold_seq, stall process counts it down
	int          hold_seq = 0;
	int          hold_len = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_recent_id_state_tracker: errors");
		$finish;
	end

	// drive result stall: long hold first, else random idling
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (want_q.size() == 0) begin
				$error("unexpected result: slot_out=%0d state_found=%0d updated=%0d",
					res.slot_out, res.state_found, res.updated);
				n_err++;
			end else begin
				due = want_q.pop_front();
				if (res.slot_out !== due.slot_out) begin
					$error("slot_out: expected %0d, got %0d", due.slot_out, res.slot_out);
					n_err++;
				end
				if (res.state_found !== due.state_found) begin
					$error("state_found: expected %0d, got %0d",
						due.state_found, res.state_found);
					n_err++;
				end
				if (res.updated !== due.updated) begin
					$error("updated: expected %0d, got %0d", due.updated, res.updated);
					n_err++;
				end
			end
		end
	end

	// apply one accepted request to the shadow table and queue its result
	task automatic track_apply(input cmd_t c);
		res_t r;
		int   i;
		int   k;
		bit   done;
		r = '0;
		case (c.opcode)
			OP_START: begin
				trk_id[trk_wp] = c.instance_id;
				trk_state[trk_wp] = ST_PENDING;
				r.slot_out = 4'(trk_wp);
				trk_wp = (trk_wp == N_SLOTS - 1) ? 0 : trk_wp + 1;
			end
			OP_UPDATE: begin
				if (int'(c.slot_in) < N_SLOTS && trk_id[c.slot_in] == c.instance_id) begin
					trk_state[c.slot_in] = c.new_state;
					r.updated = 1'b1;
				end
			end
			OP_QUERY: begin
				// walk back from the newest slot, stop at an empty one
				r.state_found = ST_NOT_TRACKED;
				i = (trk_wp > 0) ? trk_wp - 1 : N_SLOTS - 1;
				done = 1'b0;
				for (k = 0; k < N_SLOTS && !done; k++) begin
					if (trk_state[i] == ST_EMPTY) begin
						done = 1'b1;
					end else if (trk_id[i] == c.instance_id) begin
						r.state_found = trk_state[i];
						done = 1'b1;
					end else begin
						i = (i == 0) ? N_SLOTS - 1 : i - 1;
					end
				end
			end
			default: begin
				for (k = 0; k < N_SLOTS; k++)
					trk_state[k] = ST_EMPTY;
				trk_wp = 0;
			end
		endcase
		want_q.push_back(r);
	endtask

	function automatic cmd_t mk_cmd(logic [1:0] op, logic [15:0] id, logic [3:0] slot,
			logic [2:0] st);
		cmd_t c;
		c.opcode = op;
		c.instance_id = id;
		c.slot_in = slot;
		c.new_state = st;
		return c;
	endfunction

	// mostly a few recurring ids, so that matches are common
	function automatic logic [15:0] pick_id();
		logic [15:0] pool [8];
		pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h5555,
			16'hAAAA, 16'h00FF};
		if ($urandom_range(99) < 60)
			return pool[$urandom_range(7)];
		return 16'($urandom);
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t        c;
		int unsigned r;
		c = mk_cmd(OP_QUERY, pick_id(), 4'($urandom), 3'($urandom));
		r = $urandom_range(99);
		if (r < 3) begin
			c.opcode = OP_CLEAR;
		end else if (r < 40) begin
			c.opcode = OP_START;
		end else if (r < 65) begin
			c.opcode = OP_UPDATE;
			if ($urandom_range(99) < 80)
				c.instance_id = trk_id[c.slot_in];
			c.new_state = ($urandom_range(99) < 10) ? ST_EMPTY : 3'($urandom_range(1, 7));
		end else if ($urandom_range(99) < 70) begin
			c.instance_id = trk_id[$urandom_range(N_SLOTS - 1)];
		end
		return c;
	endfunction

	// offer one request, hold it until accepted, then predict it
	task automatic send_cmd(input cmd_t c);
		int gap;
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		track_apply(c);
	endtask

	task automatic quiet_tx();
		@(negedge clk);
		cmd_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		quiet_tx();
		while (want_q.size() != 0)
			@(posedge clk);
	endtask

	// reset ids are zero: an update with id 0 matches an empty slot
	task automatic test_empty_table();
		send_cmd(mk_cmd(OP_CLEAR, 16'h0000, 4'd0, 3'd0));
		send_cmd(mk_cmd(OP_UPDATE, 16'h0000, 4'd0, 3'd3));
		send_cmd(mk_cmd(OP_QUERY, 16'h0000, 4'd15, 3'd7));
	endtask

	// fill every slot, wrap the pointer, then miss on a full table
	task automatic test_fill_and_wrap();
		logic [15:0] id;
		int          k;
		for (k = 0; k < N_SLOTS; k++) begin
			id = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(1 << (k - 2));
			send_cmd(mk_cmd(OP_START, id, 4'($urandom), 3'($urandom)));
		end
		send_cmd(mk_cmd(OP_QUERY, 16'h4321, 4'd0, 3'd0));
	endtask

	// matching and mismatching updates; an emptied slot ends the walk
	task automatic test_update_rules();
		send_cmd(mk_cmd(OP_UPDATE, 16'hFFFF, 4'd1, 3'd7));
		send_cmd(mk_cmd(OP_UPDATE, 16'h1234, 4'd2, 3'd5));
		send_cmd(mk_cmd(OP_QUERY, 16'hFFFF, 4'd0, 3'd0));
		send_cmd(mk_cmd(OP_UPDATE, 16'h0008, 4'd5, ST_EMPTY));
		send_cmd(mk_cmd(OP_QUERY, 16'h0002, 4'd0, 3'd0));
	endtask

	// clear leaves the ids, so an update still matches
	task automatic test_clear_keeps_ids();
		send_cmd(mk_cmd(OP_CLEAR, 16'hFFFF, 4'd15, 3'd7));
		send_cmd(mk_cmd(OP_UPDATE, 16'hFFFF, 4'd1, 3'd4));
		send_cmd(mk_cmd(OP_QUERY, 16'hFFFF, 4'd1, 3'd0));
	endtask

	task automatic test_random_traffic(input int n, input int unsigned tx_pct,
			input int unsigned rx_pct);
		int k;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (k = 0; k < n; k++)
			send_cmd(rand_cmd());
		wait_idle();
	endtask

	// block the result side for a long stretch while requests keep coming
	task automatic test_backpressure();
		int k;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_len = 150;
		hold_seq = hold_seq + 1;
		for (k = 0; k < 20; k++)
			send_cmd(rand_cmd());
		wait_idle();
	endtask

	initial begin
		int k;
		for (k = 0; k < N_SLOTS; k++) begin
			trk_id[k] = '0;
			trk_state[k] = ST_EMPTY;
		end
		trk_wp = 0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_fill_and_wrap();
		test_update_rules();
		test_clear_keeps_ids();
		wait_idle();
		test_random_traffic(170, 38, 53);
		test_backpressure();
		test_random_traffic(170, 53, 38);
		test_random_traffic(160, 0, 0);

		wait_idle();
		repeat (N_SLOTS + 8) @(posedge clk);
		if (n_err == 0)
			$display("tb_recent_id_state_tracker: clean");
		else
			$display("tb_recent_id_state_tracker: errors");
		$finish;
	end

endmodule

`default_nettype wire
